// ===== hw/rtl/ascii_hex_frame_encoder_defines.svh =====
// Assertion macros used by the frame encoder checker.
`ifndef ASCII_HEX_FRAME_ENCODER_DEFINES_SVH
`define ASCII_HEX_FRAME_ENCODER_DEFINES_SVH

// Checked only while out of reset.
`define AHFE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define AHFE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/ahfe_pkg.sv =====
// Types, constants and helpers shared by the ASCII hex frame encoder.
package ahfe_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_START_CHAR = 2'd0;
  localparam logic [1:0] CFG_POLL_CODE  = 2'd1;
  localparam logic [1:0] CFG_USER_CODE  = 2'd2;

  // Configuration reset values
  localparam logic [7:0] START_CHAR_RST = 8'h3A;
  localparam logic [7:0] POLL_CODE_RST  = 8'h00;
  localparam logic [7:0] USER_CODE_RST  = 8'h01;

  // Frame field positions
  localparam logic [2:0] FP_HW_DST = 3'd0;
  localparam logic [2:0] FP_HW_SRC = 3'd1;
  localparam logic [2:0] FP_TYPE   = 3'd2;
  localparam logic [2:0] FP_SRC    = 3'd3;
  localparam logic [2:0] FP_DST    = 3'd4;
  localparam logic [2:0] FP_LEN    = 3'd5;
  localparam logic [2:0] FP_DATA   = 3'd6;

  // Characters
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_A    = 8'h41;
  localparam logic [7:0] NIB_HI  = 8'hF0;
  localparam logic [7:0] NIB_LO  = 8'h0F;

  // Output slots of one command, in emission order
  localparam int NSLOTS       = 7;
  localparam int SLOT_START   = 0;
  localparam int SLOT_HEX_HI  = 1;
  localparam int SLOT_HEX_LO  = 2;
  localparam int SLOT_SUM_HI  = 3;
  localparam int SLOT_SUM_LO  = 4;
  localparam int SLOT_CR      = 5;
  localparam int SLOT_LF      = 6;

  typedef logic [NSLOTS-1:0] slot_mask_t;

  // One queued command: what a single input byte makes
  typedef struct packed {
    logic       start_en;
    logic [7:0] start_ch;
    logic       hex_en;
    logic [7:0] hex_byte;
    logic       close_en;
    logic [7:0] csum;
  } cmd_t;

  // Upper-case hex character of the low nibble
  function automatic logic [7:0] hex_digit(input logic [7:0] v);
    logic [7:0] n;
    n = v & NIB_LO;
    if (n > 8'd9) begin
      hex_digit = n - 8'd10 + CH_A;
    end else begin
      hex_digit = n + CH_ZERO;
    end
  endfunction

  // Slots a command fills
  function automatic slot_mask_t cmd_mask(input cmd_t c);
    slot_mask_t m;
    m = '0;
    m[SLOT_START]  = c.start_en;
    m[SLOT_HEX_HI] = c.hex_en;
    m[SLOT_HEX_LO] = c.hex_en;
    m[SLOT_SUM_HI] = c.close_en;
    m[SLOT_SUM_LO] = c.close_en;
    m[SLOT_CR]     = c.close_en;
    m[SLOT_LF]     = c.close_en;
    cmd_mask = m;
  endfunction

endpackage

// ===== hw/rtl/ahfe_front.sv =====
// Front end: configuration registers, frame parser and command builder.
module ahfe_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_idx,
  input  logic [7:0]      cfg_wdata,
  input  logic            accept,
  input  logic [7:0]      msg_byte,
  output logic            push,
  output ahfe_pkg::cmd_t  cmd
);

  logic [7:0] start_char_r;
  logic [7:0] poll_code_r;
  logic [7:0] user_code_r;

  logic [2:0] fp_r, fp_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] type_r, type_nxt;
  logic [7:0] rem_r, rem_nxt;

  logic [7:0] sum_add;
  logic [7:0] rem_dec;
  logic       shown;
  logic       close_en;
  logic [7:0] csum;

  assign sum_add = sum_r + msg_byte;
  assign rem_dec = rem_r - 8'd1;
  assign shown   = (type_r == user_code_r) && (type_r != poll_code_r);

  // Classify the byte by its place in the frame
  always_comb begin
    fp_nxt       = fp_r;
    sum_nxt      = sum_add;
    type_nxt     = type_r;
    rem_nxt      = rem_r;
    cmd.start_en = 1'b0;
    cmd.start_ch = start_char_r;
    cmd.hex_en   = 1'b0;
    cmd.hex_byte = msg_byte;
    close_en     = 1'b0;
    csum         = sum_add;
    unique case (fp_r)
      ahfe_pkg::FP_HW_SRC: begin
        cmd.hex_en = 1'b1;
        fp_nxt     = ahfe_pkg::FP_TYPE;
      end
      ahfe_pkg::FP_TYPE: begin
        type_nxt   = msg_byte;
        cmd.hex_en = 1'b1;
        if (msg_byte == poll_code_r) begin
          // poll frame: checksum covers only the hardware addresses
          close_en = 1'b1;
          csum     = sum_r;
        end else begin
          fp_nxt = ahfe_pkg::FP_SRC;
        end
      end
      ahfe_pkg::FP_SRC, ahfe_pkg::FP_DST: begin
        cmd.hex_en = shown;
        fp_nxt     = fp_r + 3'd1;
      end
      ahfe_pkg::FP_LEN: begin
        cmd.hex_en = shown;
        rem_nxt    = msg_byte;
        if (msg_byte == 8'd0) begin
          close_en = 1'b1;
        end else begin
          fp_nxt = ahfe_pkg::FP_DATA;
        end
      end
      ahfe_pkg::FP_DATA: begin
        cmd.hex_en = shown;
        rem_nxt    = rem_dec;
        if (rem_dec == 8'd0) begin
          close_en = 1'b1;
        end
      end
      default: begin
        // hardware destination opens a frame
        cmd.start_en = 1'b1;
        cmd.hex_en   = 1'b1;
        sum_nxt      = msg_byte;
        rem_nxt      = 8'd0;
        fp_nxt       = ahfe_pkg::FP_HW_SRC;
      end
    endcase
    if (close_en) begin
      fp_nxt  = ahfe_pkg::FP_HW_DST;
      sum_nxt = 8'd0;
      rem_nxt = 8'd0;
    end
    cmd.close_en = close_en;
    cmd.csum     = csum;
  end

  // Silent body bytes make no command
  assign push = accept && (cmd.start_en || cmd.hex_en || cmd.close_en);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_char_r <= ahfe_pkg::START_CHAR_RST;
      poll_code_r  <= ahfe_pkg::POLL_CODE_RST;
      user_code_r  <= ahfe_pkg::USER_CODE_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        ahfe_pkg::CFG_START_CHAR: start_char_r <= cfg_wdata;
        ahfe_pkg::CFG_POLL_CODE:  poll_code_r  <= cfg_wdata;
        ahfe_pkg::CFG_USER_CODE:  user_code_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fp_r   <= ahfe_pkg::FP_HW_DST;
      sum_r  <= 8'd0;
      type_r <= 8'd0;
      rem_r  <= 8'd0;
    end else if (accept) begin
      fp_r   <= fp_nxt;
      sum_r  <= sum_nxt;
      type_r <= type_nxt;
      rem_r  <= rem_nxt;
    end
  end

endmodule

// ===== hw/rtl/ahfe_queue.sv =====
// Small command queue between the parser and the character sequencer.
module ahfe_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ahfe_pkg::cmd_t  wdata,
  input  logic            pop,
  output ahfe_pkg::cmd_t  rdata,
  output logic            empty,
  output logic            full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  ahfe_pkg::cmd_t entry_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r;
  logic [PW-1:0]  rd_ptr_r;
  logic [CW-1:0]  count_r;

  assign rdata = entry_r[rd_ptr_r];
  assign empty = (count_r == '0);
  assign full  = (count_r == CNT_FULL);

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wdata;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/ahfe_back.sv =====
// Back end: walks each command's slots and drives one character per word.
module ahfe_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  ahfe_pkg::cmd_t  q_rdata,
  output logic            pop,
  input  logic            out_stall,
  output logic            out_valid,
  output logic [7:0]      out_char,
  output logic            out_run_last,
  output logic            out_frame_done
);

  ahfe_pkg::slot_mask_t mask_r;
  ahfe_pkg::slot_mask_t low;
  ahfe_pkg::slot_mask_t rest;
  ahfe_pkg::cmd_t       cmd_r;

  logic       out_valid_r;
  logic [7:0] out_char_r;
  logic       out_run_last_r;
  logic       out_frame_done_r;

  logic       busy;
  logic       out_ready;
  logic       fire;
  logic [7:0] ch_sel;

  assign low       = mask_r & (~mask_r + 1'b1);
  assign rest      = mask_r & ~low;
  assign busy      = |mask_r;
  assign out_ready = !out_valid_r || !out_stall;
  assign fire      = busy && out_ready;
  assign pop       = !q_empty && (!busy || (fire && (rest == '0)));

  // Character of the current slot
  always_comb begin
    priority if (low[ahfe_pkg::SLOT_START]) begin
      ch_sel = cmd_r.start_ch;
    end else if (low[ahfe_pkg::SLOT_HEX_HI]) begin
      ch_sel = ahfe_pkg::hex_digit((cmd_r.hex_byte & ahfe_pkg::NIB_HI) >> 4);
    end else if (low[ahfe_pkg::SLOT_HEX_LO]) begin
      ch_sel = ahfe_pkg::hex_digit(cmd_r.hex_byte);
    end else if (low[ahfe_pkg::SLOT_SUM_HI]) begin
      ch_sel = ahfe_pkg::hex_digit((cmd_r.csum & ahfe_pkg::NIB_HI) >> 4);
    end else if (low[ahfe_pkg::SLOT_SUM_LO]) begin
      ch_sel = ahfe_pkg::hex_digit(cmd_r.csum);
    end else if (low[ahfe_pkg::SLOT_CR]) begin
      ch_sel = ahfe_pkg::CH_CR;
    end else begin
      ch_sel = ahfe_pkg::CH_LF;
    end
  end

  // Slot mask and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid_r <= fire;
      end
      if (pop) begin
        mask_r <= ahfe_pkg::cmd_mask(q_rdata);
      end else if (fire) begin
        mask_r <= rest;
      end
    end
  end

  // Command and output payload
  always_ff @(posedge clk) begin
    if (pop) begin
      cmd_r <= q_rdata;
    end
    if (fire) begin
      out_char_r       <= ch_sel;
      out_run_last_r   <= (rest == '0);
      out_frame_done_r <= low[ahfe_pkg::SLOT_LF];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_char       = out_char_r;
  assign out_run_last   = out_run_last_r;
  assign out_frame_done = out_frame_done_r;

endmodule

// ===== hw/rtl/ascii_hex_frame_encoder.sv =====
// A taken byte is written into the command queue, popped into the back end's slot mask, and
// its first character is then registered at the output. Throughput: one character per cycle
// while out_stall is low; a byte makes 0 to 6 characters (at least 2 for any shown byte).
// A byte that makes no character pushes no command; the command queue decouples the two sides.
// Reset (synchronous, rst_n low) empties the queue, clears the parser and
// returns the configuration registers to their defaults.
module ascii_hex_frame_encoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_idx,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_msg_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       out_run_last,
  output logic       out_frame_done
);

  logic           accept;
  logic           push;
  logic           pop;
  logic           q_empty;
  logic           q_full;
  ahfe_pkg::cmd_t cmd;
  ahfe_pkg::cmd_t q_rdata;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  // Parser
  ahfe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .msg_byte  (in_msg_byte),
    .push      (push),
    .cmd       (cmd)
  );

  // Command queue
  ahfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (cmd),
    .pop   (pop),
    .rdata (q_rdata),
    .empty (q_empty),
    .full  (q_full)
  );

  // Character sequencer
  ahfe_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_rdata        (q_rdata),
    .pop            (pop),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_char       (out_char),
    .out_run_last   (out_run_last),
    .out_frame_done (out_frame_done)
  );

endmodule

// ===== hw/rtl/ahfe_checker.sv =====
// Port-level checker for the frame encoder, bound to the top level.
`include "ascii_hex_frame_encoder_defines.svh"

module ahfe_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_char,
  input logic       out_run_last,
  input logic       out_frame_done
);

  // a stalled output word holds
  `AHFE_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_char), "output word changed while stalled")

  // frame close is an LF that also ends its byte's run
  `AHFE_ASSERT(a_done_lf, out_valid && out_frame_done |-> out_char == ahfe_pkg::CH_LF && out_run_last, "frame close is not a final LF")

  // a run-ending LF word right after an accepted CR word is marked as a frame close
  `AHFE_ASSERT(a_done_after_cr, out_valid && !out_stall && !out_frame_done && !out_run_last && out_char == ahfe_pkg::CH_CR |=> !out_valid || out_frame_done || out_char != ahfe_pkg::CH_LF || !out_run_last, "CR not followed by closing LF")

  // nothing valid right after reset
  `AHFE_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid, "output valid after reset")

endmodule

bind ascii_hex_frame_encoder ahfe_checker u_ahfe_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_char       (out_char),
  .out_run_last   (out_run_last),
  .out_frame_done (out_frame_done)
);

// ===== dv/tb.sv =====
// Self-checking testbench for the ASCII hex frame encoder: queued byte driver and char checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // no handshake on either side for this long means the block is stuck
  localparam int IDLE_LIMIT = 2000;
  // margin after the last char so the output register and queue are empty
  localparam int SETTLE_CYC = 16;
  localparam int PHASE_WORDS = 6;
  localparam int LONG_LEN = 16;

  typedef struct packed {
    logic [7:0] ch;
    logic       run_last;
    logic       frame_done;
  } frame_char_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_idx = ahfe_pkg::CFG_START_CHAR;
  logic [7:0] cfg_wdata = 8'h00;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_msg_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_char;
  logic       out_run_last;
  logic       out_frame_done;

  ascii_hex_frame_encoder uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_msg_byte   (in_msg_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_char      (out_char),
    .out_run_last  (out_run_last),
    .out_frame_done(out_frame_done)
  );

  // encoder image: register copies and parser state
  logic [7:0] enc_start = ahfe_pkg::START_CHAR_RST;
  logic [7:0] enc_poll  = ahfe_pkg::POLL_CODE_RST;
  logic [7:0] enc_user  = ahfe_pkg::USER_CODE_RST;
  logic [2:0] enc_pos   = ahfe_pkg::FP_HW_DST;
  logic [7:0] enc_sum   = 8'h00;
  logic [7:0] enc_type  = 8'h00;
  logic [7:0] enc_left  = 8'h00;

  frame_char_t expected_chars[$];
  logic [7:0]  pending_bytes[$];

  int          n_err = 0;
  int          n_queued = 0;
  int          n_taken = 0;
  int          n_chars = 0;
  int          n_frames = 0;
  int          n_settings = 0;
  int          idle_cyc = 0;
  int unsigned in_gap = 0;
  int unsigned out_hold = 0;
  logic        in_took = 1'b0;
  logic        no_idle = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 85) return $urandom_range(1, 2);
    else if (r < 97) return $urandom_range(3, 8);
    else return $urandom_range(15, 40);
  endfunction

  function automatic logic [7:0] nib_char(input logic [3:0] nib);
    return (nib < 4'd10) ? (ahfe_pkg::CH_ZERO + {4'h0, nib})
                         : (ahfe_pkg::CH_A - 8'd10 + {4'h0, nib});
  endfunction

  task automatic push_char(input logic [7:0] c, input logic done);
    frame_char_t fc;
    fc.ch = c;
    fc.run_last = 1'b0;
    fc.frame_done = done;
    expected_chars.push_back(fc);
  endtask

  task automatic push_hex(input logic [7:0] b);
    push_char(nib_char(b[7:4]), 1'b0);
    push_char(nib_char(b[3:0]), 1'b0);
  endtask

  // checksum, CR, LF, then back to the first field
  task automatic close_frame_chars();
    push_hex(enc_sum);
    push_char(ahfe_pkg::CH_CR, 1'b0);
    push_char(ahfe_pkg::CH_LF, 1'b1);
    enc_pos = ahfe_pkg::FP_HW_DST;
    enc_sum = 8'h00;
    enc_left = 8'h00;
  endtask

  // chars that one message byte makes
  task automatic encode_byte(input logic [7:0] b);
    int          n0;
    logic        shown;
    frame_char_t last;
    n0 = expected_chars.size();
    shown = (enc_type == enc_user) && (enc_type != enc_poll);
    case (enc_pos)
      ahfe_pkg::FP_HW_SRC: begin
        push_hex(b);
        enc_sum += b;
        enc_pos = ahfe_pkg::FP_TYPE;
      end
      ahfe_pkg::FP_TYPE: begin
        enc_type = b;
        push_hex(b);
        if (b == enc_poll) begin
          close_frame_chars();
        end else begin
          enc_sum += b;
          enc_pos = ahfe_pkg::FP_SRC;
        end
      end
      ahfe_pkg::FP_SRC, ahfe_pkg::FP_DST: begin
        enc_sum += b;
        if (shown) push_hex(b);
        enc_pos = enc_pos + 3'd1;
      end
      ahfe_pkg::FP_LEN: begin
        enc_sum += b;
        enc_left = b;
        if (shown) push_hex(b);
        if (b == 8'h00) close_frame_chars();
        else enc_pos = ahfe_pkg::FP_DATA;
      end
      ahfe_pkg::FP_DATA: begin
        enc_sum += b;
        if (shown) push_hex(b);
        enc_left = enc_left - 8'd1;
        if (enc_left == 8'h00) close_frame_chars();
      end
      default: begin
        push_char(enc_start, 1'b0);
        push_hex(b);
        enc_sum = b;
        enc_left = 8'h00;
        enc_pos = ahfe_pkg::FP_HW_SRC;
      end
    endcase
    // mark the last char of this byte
    if (expected_chars.size() > n0) begin
      last = expected_chars.pop_back();
      last.run_last = 1'b1;
      expected_chars.push_back(last);
    end
  endtask

  // byte driver: holds a stalled word, otherwise takes the next one after a gap
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_took) begin
      // stalled, keep the word
    end else if (in_gap > 0) begin
      in_valid <= 1'b0;
      in_gap = in_gap - 1;
    end else if (pending_bytes.size() > 0) begin
      in_valid <= 1'b1;
      in_msg_byte <= pending_bytes.pop_front();
      in_gap = no_idle ? 0 : pick_gap();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // char sink back-pressure
  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_stall <= 1'b1;
      out_hold = out_hold - 1;
    end else begin
      out_stall <= 1'b0;
      out_hold = no_idle ? 0 : pick_gap();
    end
  end

  // char checker and byte predictor
  always @(posedge clk) begin
    frame_char_t want;
    in_took = 1'b0;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        n_chars++;
        if (expected_chars.size() == 0) begin
          $error("unexpected char 0x%02h", out_char);
          n_err++;
        end else begin
          want = expected_chars.pop_front();
          if (want.frame_done) n_frames++;
          if (out_char !== want.ch) begin
            $error("out_char: expected 0x%02h, got 0x%02h", want.ch, out_char);
            n_err++;
          end
          if (out_run_last !== want.run_last) begin
            $error("out_run_last: expected %0b, got %0b", want.run_last, out_run_last);
            n_err++;
          end
          if (out_frame_done !== want.frame_done) begin
            $error("out_frame_done: expected %0b, got %0b", want.frame_done, out_frame_done);
            n_err++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        in_took = 1'b1;
        n_taken++;
        encode_byte(in_msg_byte);
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cyc = 0;
    else idle_cyc++;
    if (idle_cyc >= IDLE_LIMIT) begin
      $error("no handshake for %0d cycles", IDLE_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  task automatic queue_byte(input logic [7:0] b);
    pending_bytes.push_back(b);
    n_queued++;
  endtask

  // one frame in field order; keep >= 0 cuts it short after that many bytes
  task automatic queue_frame(input logic [7:0] hd, hs, typ, sa, da, input int len, keep);
    logic [7:0] fb[$];
    fb.push_back(hd);
    fb.push_back(hs);
    fb.push_back(typ);
    if (typ != enc_poll) begin
      fb.push_back(sa);
      fb.push_back(da);
      fb.push_back(8'(len));
      for (int i = 0; i < len; i++) fb.push_back(8'($urandom));
    end
    foreach (fb[i]) begin
      if (keep < 0 || i < keep) queue_byte(fb[i]);
    end
  endtask

  task automatic queue_random_frame(input int keep);
    logic [7:0] typ;
    int         len;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 25) typ = enc_poll;
    else if (r < 65) typ = enc_user;
    else typ = 8'($urandom);
    r = $urandom_range(0, 99);
    if (r < 20) len = 0;
    else if (r < 90) len = $urandom_range(1, 4);
    else len = $urandom_range(5, 12);
    queue_frame(8'($urandom), 8'($urandom), typ, 8'($urandom), 8'($urandom), len, keep);
  endtask

  // mostly whole frames, some stray bytes and cut frames
  task automatic queue_random_words(input int target);
    int          first;
    int unsigned r;
    first = n_queued;
    while (n_queued - first < target) begin
      r = $urandom_range(0, 99);
      if (r < 85) queue_random_frame(-1);
      else if (r < 92) repeat ($urandom_range(1, 4)) queue_byte(8'($urandom));
      else queue_random_frame($urandom_range(1, 6));
    end
  endtask

  // block idle: every word taken, every char seen
  task automatic wait_idle();
    while (n_taken != n_queued || expected_chars.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    case (idx)
      ahfe_pkg::CFG_START_CHAR: enc_start = val;
      ahfe_pkg::CFG_POLL_CODE:  enc_poll = val;
      default:                  enc_user = val;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_codes(input logic [7:0] st, poll, user);
    write_reg(ahfe_pkg::CFG_START_CHAR, st);
    write_reg(ahfe_pkg::CFG_POLL_CODE, poll);
    write_reg(ahfe_pkg::CFG_USER_CODE, user);
    n_settings++;
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // reset codes: poll with address extremes, user, zero length, silent type
    queue_frame(8'h00, 8'hFF, ahfe_pkg::POLL_CODE_RST, 8'h00, 8'h00, 0, -1);
    queue_frame(8'hFF, 8'h00, ahfe_pkg::USER_CODE_RST, 8'hA5, 8'h5A, 2, -1);
    queue_frame(8'hC3, 8'h3C, ahfe_pkg::USER_CODE_RST, 8'hFF, 8'h00, 0, -1);
    queue_frame(8'h12, 8'h34, 8'h80, 8'h9B, 8'hE7, 1, -1);
    wait_idle();

    // poll and user codes equal: poll wins
    set_codes(8'h00, 8'hFF, 8'hFF);
    queue_frame(8'h01, 8'h02, 8'hFF, 8'h00, 8'h00, 0, -1);
    queue_frame(8'h7F, 8'h80, 8'h01, 8'h11, 8'h22, 2, -1);
    queue_random_words(PHASE_WORDS);
    wait_idle();

    // extreme start char; leave a user frame open across the next write
    set_codes(8'hFF, 8'h00, 8'hFF);
    queue_random_words(PHASE_WORDS);
    queue_frame(8'h5E, 8'hE5, enc_user, 8'h33, 8'hCC, 3, 5);
    wait_idle();

    // user code moves mid-frame, then one long frame
    set_codes(8'h3A, 8'h80, 8'h7F);
    queue_byte(8'h03);
    queue_byte(8'h44);
    queue_byte(8'h55);
    queue_byte(8'h66);
    queue_frame(8'hAA, 8'h55, enc_user, 8'h0F, 8'hF0, LONG_LEN, -1);
    queue_random_words(PHASE_WORDS);
    wait_idle();

    // back-to-back stretch with random codes
    no_idle = 1'b1;
    set_codes(8'($urandom), 8'($urandom), 8'($urandom));
    queue_random_words(PHASE_WORDS);
    wait_idle();
    no_idle = 1'b0;

    repeat (2) begin
      set_codes(8'($urandom), 8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)));
      queue_random_words(PHASE_WORDS);
      wait_idle();
    end

    if (expected_chars.size() != 0) begin
      $error("%0d expected chars never came", expected_chars.size());
      n_err++;
    end
    $display("run: %0d bytes in, %0d chars checked, %0d frames closed",
             n_taken, n_chars, n_frames);
    $display("run: %0d code settings incl. equal codes, mid-frame changes, long data body",
             n_settings);
    if (n_err == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/ahfe_pkg.sv
hw/rtl/ahfe_front.sv
hw/rtl/ahfe_queue.sv
hw/rtl/ahfe_back.sv
hw/rtl/ascii_hex_frame_encoder.sv
hw/rtl/ahfe_checker.sv
dv/tb.sv
